### rtl/stratified_grid_sample_generator_macros.svh
// Assertion helpers used by the checker file.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef STRATIFIED_GRID_SAMPLE_GENERATOR_MACROS_SVH
`define STRATIFIED_GRID_SAMPLE_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define SGSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sgsg_pkg.sv
`default_nettype none
package sgsg_pkg;

  localparam int COORD_W       = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int SEED_W        = 48;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_CELLS_DEF = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RMIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RMAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 3'd5;

  // sampling modes
  localparam logic [1:0] MODE_RANDOM  = 2'd0;
  localparam logic [1:0] MODE_JITTER  = 2'd1;
  localparam logic [1:0] MODE_UNIFORM = 2'd2;
  localparam logic [1:0] MODE_REGULAR = 2'd3;

  // destinations of a fresh random fraction
  localparam logic [1:0] DST_SHIFT_X = 2'd0;
  localparam logic [1:0] DST_SHIFT_Y = 2'd1;
  localparam logic [1:0] DST_SHIFT_Z = 2'd2;
  localparam logic [1:0] DST_OFFSET  = 2'd3;

  // reset values of the registers
  localparam logic [1:0]                MODE_RST  = MODE_JITTER;
  localparam logic [1:0]                DIMS_RST  = 2'd2;
  localparam logic [6:0]                CELLS_RST = 7'd8;
  localparam logic signed [COORD_W-1:0] RMIN_RST  = 32'sd0;
  localparam logic signed [COORD_W-1:0] RMAX_RST  = 32'sd65536;
  localparam logic [SEED_W-1:0]         SEED_RST  = 48'd20017429951246;

  // drand48 generator, multiplier split at bit 32
  localparam logic [31:0]       LCG_MUL_LO = 32'hDEEC_E66D;
  localparam logic [2:0]        LCG_MUL_HI = 3'h5;
  localparam logic [SEED_W-1:0] LCG_ADD    = 48'hB;

  typedef struct packed {
    logic       start;
    logic       restart;
    logic       lcg_mul;
    logic       lcg_add;
    logic [1:0] add_dst;
    logic       scale_mul;
    logic       div_load;
    logic       div_step;
    logic       store;
    logic       emit;
    logic [1:0] axis;
  } sgsg_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] dims;
    logic       div_last;
    logic       out_free;
  } sgsg_sts_t;

endpackage
`default_nettype wire

### rtl/sgsg_ifs.sv
`default_nettype none

interface sgsg_in_if import sgsg_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sgsg_out_if import sgsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic                      last_point;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output last_point, input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                input last_point, output ready);
endinterface

interface sgsg_cfg_if import sgsg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/sgsg_ctrl.sv
`default_nettype none
module sgsg_ctrl import sgsg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_restart,
  output logic      in_ready,
  input  sgsg_sts_t sts,
  output sgsg_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RS_MUL   = 4'd1;
  localparam logic [3:0] S_RS_ADD   = 4'd2;
  localparam logic [3:0] S_AX_BEGIN = 4'd3;
  localparam logic [3:0] S_AX_MUL   = 4'd4;
  localparam logic [3:0] S_AX_ADD   = 4'd5;
  localparam logic [3:0] S_SC_MUL   = 4'd6;
  localparam logic [3:0] S_DIV_LD   = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_STORE    = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] draw_r, draw_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    draw_nxt  = draw_r;
    axis_nxt  = axis_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start   = 1'b1;
          cmd.restart = in_restart;
          draw_nxt    = '0;
          axis_nxt    = '0;
          state_nxt   = in_restart ? S_RS_MUL : S_AX_BEGIN;
        end
      end
      S_RS_MUL: begin
        cmd.lcg_mul = 1'b1;
        state_nxt   = S_RS_ADD;
      end
      S_RS_ADD: begin
        // draw index runs x, y, z, matching the shift destination codes
        cmd.lcg_add = 1'b1;
        cmd.add_dst = draw_r;
        if (draw_r == DST_SHIFT_Z) begin
          state_nxt = S_AX_BEGIN;
        end else begin
          draw_nxt  = draw_r + 2'd1;
          state_nxt = S_RS_MUL;
        end
      end
      S_AX_BEGIN: begin
        if (sts.mode == MODE_RANDOM || sts.mode == MODE_JITTER) begin
          state_nxt = S_AX_MUL;
        end else begin
          state_nxt = S_SC_MUL;
        end
      end
      S_AX_MUL: begin
        cmd.lcg_mul = 1'b1;
        state_nxt   = S_AX_ADD;
      end
      S_AX_ADD: begin
        cmd.lcg_add = 1'b1;
        cmd.add_dst = DST_OFFSET;
        state_nxt   = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd.scale_mul = 1'b1;
        state_nxt     = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (axis_r == sts.dims - 2'd1) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_AX_BEGIN;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      draw_r  <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      draw_r  <= draw_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/sgsg_dpath.sv
`default_nettype none
module sgsg_dpath import sgsg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  sgsg_cmd_t                 cmd,
  output sgsg_sts_t                 sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_coord_x,
  output logic signed [COORD_W-1:0] out_coord_y,
  output logic signed [COORD_W-1:0] out_coord_z,
  output logic                      out_last_point
);

  localparam int CW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int NW    = $clog2(MAX_CELLS + 1);
  localparam int MAGW  = COORD_W + 1;
  localparam int TW    = CW + FRAC_BITS;
  localparam int PW    = MAGW + TW;
  localparam int DW    = PW - FRAC_BITS;
  localparam int DSTEP = 8;
  localparam int DCYC  = (DW + DSTEP - 1) / DSTEP;
  localparam int DWP   = DCYC * DSTEP;
  localparam int DCW   = (DCYC > 1) ? $clog2(DCYC) : 1;
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // configuration
  logic [1:0]                mode_r, mode_nxt;
  logic [1:0]                dims_r, dims_nxt;
  logic [6:0]                cells_cfg_r, cells_cfg_nxt;
  logic signed [COORD_W-1:0] rmin_r, rmin_nxt;
  logic signed [COORD_W-1:0] rmax_r, rmax_nxt;

  // generator and set state
  logic [SEED_W-1:0]    rng_r, rng_nxt;
  logic [CW-1:0]        cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [FRAC_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;

  // per-request working registers
  logic [1:0]                mode_w_r, mode_w_nxt;
  logic [1:0]                dims_w_r, dims_w_nxt;
  logic [NW-1:0]             cells_w_r, cells_w_nxt;
  logic [MAGW-1:0]           mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [SEED_W-1:0]         pl_r, pl_nxt;
  logic [15:0]               ph_r, ph_nxt;
  logic [FRAC_BITS-1:0]      off_r, off_nxt;
  logic [PW-1:0]             prod_r, prod_nxt;
  logic [DWP-1:0]            dv_r, dv_nxt;
  logic [NW-1:0]             rem_r, rem_nxt;
  logic [DCW-1:0]            dcnt_r, dcnt_nxt;
  logic signed [COORD_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt, res_z_r, res_z_nxt;

  // output register
  logic                      ovalid_r, ovalid_nxt;
  logic signed [COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic                      olast_r, olast_nxt;

  // combinational helpers
  logic [1:0]                dims_eff;
  logic [NW-1:0]             cells_eff;
  logic [CW-1:0]             top_c;
  logic [MAGW-1:0]           range_v;
  logic [MAGW-1:0]           mag_v;
  logic [63:0]               mul_lo_v;
  logic [31:0]               mul_ha_v;
  logic [18:0]               mul_hb_v;
  logic [SEED_W-1:0]         rng_sum_v;
  logic [FRAC_BITS-1:0]      frac_v;
  logic [CW-1:0]             cell_sel;
  logic [FRAC_BITS-1:0]      off_sel;
  logic [TW-1:0]             t_val;
  logic [NW-1:0]             dsor;
  logic [NW:0]               trial;
  logic [NW-1:0]             rem_v;
  logic [DWP-1:0]            dv_v;
  logic signed [COORD_W-1:0] store_v;
  logic                      last_v;
  logic                      adv_go;
  logic [CW-1:0]             adv_x, adv_y, adv_z;

  assign dims_eff  = (dims_r == 2'd0) ? 2'd1 : dims_r;
  assign cells_eff = (cells_cfg_r == 7'd0) ? NW'(1) :
                     ((int'(cells_cfg_r) > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(cells_cfg_r));
  assign top_c     = CW'(cells_eff - NW'(1));

  assign range_v = {rmax_r[COORD_W-1], rmax_r} - {rmin_r[COORD_W-1], rmin_r};
  assign mag_v   = range_v[MAGW-1] ? (~range_v + MAGW'(1)) : range_v;

  // state * multiplier mod 2^48, low and high halves in separate products
  assign mul_lo_v  = {32'b0, rng_r[31:0]} * {32'b0, LCG_MUL_LO};
  assign mul_ha_v  = {16'b0, rng_r[47:32]} * {16'b0, LCG_MUL_LO[15:0]};
  assign mul_hb_v  = {3'b0, rng_r[15:0]} * {16'b0, LCG_MUL_HI};
  assign rng_sum_v = pl_r + {ph_r, 32'b0} + LCG_ADD;
  assign frac_v    = rng_sum_v[SEED_W-1 -: FRAC_BITS];

  always_comb begin
    cell_sel = cx_r;
    off_sel  = off_r;
    case (cmd.axis)
      2'd0:    cell_sel = cx_r;
      2'd1:    cell_sel = cy_r;
      default: cell_sel = cz_r;
    endcase
    case (mode_w_r)
      MODE_UNIFORM: begin
        case (cmd.axis)
          2'd0:    off_sel = sx_r;
          2'd1:    off_sel = sy_r;
          default: off_sel = sz_r;
        endcase
      end
      MODE_REGULAR: off_sel = HALF;
      default:      off_sel = off_r;
    endcase
    if (mode_w_r == MODE_RANDOM) begin
      cell_sel = '0;
    end
  end

  assign t_val = {cell_sel, off_sel};
  assign dsor  = (mode_w_r == MODE_RANDOM) ? NW'(1) : cells_w_r;

  // restoring division by the cell count (by one in random mode), DSTEP quotient bits a cycle
  always_comb begin
    rem_v = rem_r;
    dv_v  = dv_r;
    trial = '0;
    for (int i = 0; i < DSTEP; i++) begin
      trial = {rem_v, dv_v[DWP-1]};
      dv_v  = {dv_v[DWP-2:0], 1'b0};
      if (trial >= {1'b0, dsor}) begin
        trial   = trial - {1'b0, dsor};
        dv_v[0] = 1'b1;
      end
      rem_v = trial[NW-1:0];
    end
  end

  // quotient never exceeds the range magnitude, so 32 bits and wraparound suffice
  assign store_v = neg_r ? (rmin_r - signed'(dv_r[COORD_W-1:0]))
                         : (rmin_r + signed'(dv_r[COORD_W-1:0]));

  assign last_v = (cx_r == top_c) && (dims_w_r < 2'd2 || cy_r == top_c)
               && (dims_w_r < 2'd3 || cz_r == top_c);

  // advance z fastest, then x, then y
  always_comb begin
    adv_x  = cx_r;
    adv_y  = cy_r;
    adv_z  = cz_r;
    adv_go = 1'b1;
    if (dims_w_r == 2'd3) begin
      if (cz_r < top_c) begin
        adv_z  = cz_r + CW'(1);
        adv_go = 1'b0;
      end else begin
        adv_z = '0;
      end
    end
    if (adv_go) begin
      if (cx_r < top_c) begin
        adv_x = cx_r + CW'(1);
      end else begin
        adv_x = '0;
        if (dims_w_r >= 2'd2) begin
          adv_y = (cy_r < top_c) ? (cy_r + CW'(1)) : '0;
        end
      end
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    dims_nxt      = dims_r;
    cells_cfg_nxt = cells_cfg_r;
    rmin_nxt      = rmin_r;
    rmax_nxt      = rmax_r;
    rng_nxt       = rng_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sz_nxt        = sz_r;
    mode_w_nxt    = mode_w_r;
    dims_w_nxt    = dims_w_r;
    cells_w_nxt   = cells_w_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    pl_nxt        = pl_r;
    ph_nxt        = ph_r;
    off_nxt       = off_r;
    prod_nxt      = prod_r;
    dv_nxt        = dv_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_z_nxt     = res_z_r;
    ovalid_nxt    = ovalid_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    oz_nxt        = oz_r;
    olast_nxt     = olast_r;

    if (cmd.start) begin
      mode_w_nxt  = mode_r;
      dims_w_nxt  = dims_eff;
      cells_w_nxt = cells_eff;
      mag_nxt     = mag_v;
      neg_nxt     = range_v[MAGW-1];
      res_x_nxt   = '0;
      res_y_nxt   = '0;
      res_z_nxt   = '0;
      if (cmd.restart) begin
        cx_nxt = '0;
        cy_nxt = '0;
        cz_nxt = '0;
      end else begin
        cx_nxt = (cx_r > top_c) ? top_c : cx_r;
        cy_nxt = (cy_r > top_c) ? top_c : cy_r;
        cz_nxt = (cz_r > top_c) ? top_c : cz_r;
      end
    end

    if (cmd.lcg_mul) begin
      pl_nxt = mul_lo_v[SEED_W-1:0];
      ph_nxt = mul_ha_v[15:0] + mul_hb_v[15:0];
    end

    if (cmd.lcg_add) begin
      rng_nxt = rng_sum_v;
      case (cmd.add_dst)
        DST_SHIFT_X: sx_nxt  = frac_v;
        DST_SHIFT_Y: sy_nxt  = frac_v;
        DST_SHIFT_Z: sz_nxt  = frac_v;
        default:     off_nxt = frac_v;
      endcase
    end

    if (cmd.scale_mul) begin
      prod_nxt = PW'(mag_r) * PW'(t_val);
    end

    if (cmd.div_load) begin
      dv_nxt   = DWP'(prod_r[PW-1:FRAC_BITS]);
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end

    if (cmd.div_step) begin
      dv_nxt   = dv_v;
      rem_nxt  = rem_v;
      dcnt_nxt = dcnt_r + DCW'(1);
    end

    if (cmd.store) begin
      case (cmd.axis)
        2'd0:    res_x_nxt = store_v;
        2'd1:    res_y_nxt = store_v;
        default: res_z_nxt = store_v;
      endcase
    end

    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      ox_nxt     = res_x_r;
      oy_nxt     = res_y_r;
      oz_nxt     = res_z_r;
      olast_nxt  = last_v;
      cx_nxt     = adv_x;
      cy_nxt     = adv_y;
      cz_nxt     = adv_z;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE: mode_nxt = cfg_data[1:0];
        CFG_DIMS: begin
          dims_nxt = cfg_data[1:0];
          cx_nxt   = '0;
          cy_nxt   = '0;
          cz_nxt   = '0;
        end
        CFG_CELLS: begin
          cells_cfg_nxt = cfg_data[6:0];
          cx_nxt        = '0;
          cy_nxt        = '0;
          cz_nxt        = '0;
        end
        CFG_RMIN: rmin_nxt = signed'(cfg_data[COORD_W-1:0]);
        CFG_RMAX: rmax_nxt = signed'(cfg_data[COORD_W-1:0]);
        CFG_SEED: rng_nxt  = cfg_data[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RST;
      dims_r      <= DIMS_RST;
      cells_cfg_r <= CELLS_RST;
      rmin_r      <= RMIN_RST;
      rmax_r      <= RMAX_RST;
      rng_r       <= SEED_RST;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sz_r        <= '0;
      mode_w_r    <= MODE_RST;
      dims_w_r    <= DIMS_RST;
      dcnt_r      <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      dims_r      <= dims_nxt;
      cells_cfg_r <= cells_cfg_nxt;
      rmin_r      <= rmin_nxt;
      rmax_r      <= rmax_nxt;
      rng_r       <= rng_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cz_r        <= cz_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      sz_r        <= sz_nxt;
      mode_w_r    <= mode_w_nxt;
      dims_w_r    <= dims_w_nxt;
      dcnt_r      <= dcnt_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_w_r <= cells_w_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    pl_r      <= pl_nxt;
    ph_r      <= ph_nxt;
    off_r     <= off_nxt;
    prod_r    <= prod_nxt;
    dv_r      <= dv_nxt;
    rem_r     <= rem_nxt;
    res_x_r   <= res_x_nxt;
    res_y_r   <= res_y_nxt;
    res_z_r   <= res_z_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    oz_r      <= oz_nxt;
    olast_r   <= olast_nxt;
  end

  assign sts.mode     = mode_w_r;
  assign sts.dims     = dims_w_r;
  assign sts.div_last = (dcnt_r == DCW'(DCYC - 1));
  assign sts.out_free = !ovalid_r || out_ready;

  assign out_valid      = ovalid_r;
  assign out_coord_x    = ox_r;
  assign out_coord_y    = oy_r;
  assign out_coord_z    = oz_r;
  assign out_last_point = olast_r;

endmodule
`default_nettype wire

### rtl/stratified_grid_sample_generator.sv
// Channel   Dir  Payload                                  Role
// in_ch     in   restart                                  one request = one point
// out_ch    out  coord_x, coord_y, coord_z, last_point    one point per request
// cfg_ch    in   index, data                              register write, always ready
//
// Per request: a restart first draws the three shifts; then each used axis takes a
//   draw in random and jittered modes, a scaling multiply, a division and a store.
// The shared divider takes 8 quotient bits a cycle; a generator step is a multiply
//   followed by an add.
// Reset: registers take their defaults, the generator loads the seed, counters clear.
// Stalls: a finished point waits in the output register; the next request is taken
//   as soon as that point has been loaded, even while it is still waiting.
`default_nettype none
module stratified_grid_sample_generator import sgsg_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sgsg_in_if.sink    in_ch,
  sgsg_out_if.source out_ch,
  sgsg_cfg_if.sink   cfg_ch
);

  sgsg_cmd_t cmd;
  sgsg_sts_t sts;
  logic      in_ready;

  // Writes must arrive only while idle; the block does not enforce this and takes them at once.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Sequence generator draws, scaling multiply, division, result store and emit.
  sgsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold config, generator, cell counters and the output register.
  sgsg_dpath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_CELLS (MAX_CELLS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_coord_x    (out_ch.coord_x),
    .out_coord_y    (out_ch.coord_y),
    .out_coord_z    (out_ch.coord_z),
    .out_last_point (out_ch.last_point)
  );

endmodule
`default_nettype wire

### rtl/sgsg_checker.sv
`default_nettype none
`include "stratified_grid_sample_generator_macros.svh"
module sgsg_checker import sgsg_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_coord_x,
  input logic signed [COORD_W-1:0] out_coord_y,
  input logic signed [COORD_W-1:0] out_coord_z,
  input logic                      out_last_point,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [CFG_IDX_W-1:0]      cfg_index,
  input logic [CFG_DATA_W-1:0]     cfg_data
);

  // Track the axis count of the request whose point is on the output.
  logic [1:0] dims_cfg_r, dims_cfg_nxt;
  logic [1:0] dims_req_r, dims_req_nxt;
  logic [1:0] dims_shown_r, dims_shown_nxt;

  always_comb begin
    dims_cfg_nxt   = dims_cfg_r;
    dims_req_nxt   = dims_req_r;
    dims_shown_nxt = dims_shown_r;
    if (cfg_valid && cfg_ready && cfg_index == CFG_DIMS) begin
      dims_cfg_nxt = cfg_data[1:0];
    end
    if (in_valid && in_ready) begin
      dims_req_nxt = dims_cfg_r;
    end
    if (!out_valid || out_ready) begin
      dims_shown_nxt = dims_req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_cfg_r   <= DIMS_RST;
      dims_req_r   <= DIMS_RST;
      dims_shown_r <= DIMS_RST;
    end else begin
      dims_cfg_r   <= dims_cfg_nxt;
      dims_req_r   <= dims_req_nxt;
      dims_shown_r <= dims_shown_nxt;
    end
  end

  `SGSG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SGSG_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_coord_x) && $stable(out_coord_y) && $stable(out_coord_z) && $stable(out_last_point), "stalled result changed")
  `SGSG_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `SGSG_ASSERT_IMP(a_unused_z_zero, out_valid && dims_shown_r != 2'd3, out_coord_z == 32'sd0, "z set on a point with fewer than three axes")

endmodule

bind stratified_grid_sample_generator sgsg_checker u_sgsg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_coord_x    (out_ch.coord_x),
  .out_coord_y    (out_ch.coord_y),
  .out_coord_z    (out_ch.coord_z),
  .out_last_point (out_ch.last_point),
  .cfg_valid      (cfg_ch.valid),
  .cfg_ready      (cfg_ch.ready),
  .cfg_index      (cfg_ch.index),
  .cfg_data       (cfg_ch.data)
);
`default_nettype wire

### tb/stratified_grid_sample_generator_test.sv
`default_nettype none
module stratified_grid_sample_generator_test import sgsg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Generator and grid constants of the point predictor below.
  localparam logic [47:0] LCG_MULT     = 48'h5_DEEC_E66D;
  localparam logic [47:0] LCG_INC      = 48'hB;
  localparam int          CELL_LIMIT   = 64;
  localparam logic [15:0] CELL_CENTER  = 16'h8000;
  localparam longint      SAT_HI       = 64'sd2147483647;
  localparam longint      SAT_LO       = -64'sd2147483648;
  // Give the tail some margin beyond the longest request.
  localparam int          DRAIN_CYCLES = 64;

  // Register indexes past the seed; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_t;

  // One line of the directed script: a register write or a point request,
  // the latter optionally carrying a hand-computed point.
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    bit                    known;
    point_t                want;
  } stim_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sgsg_in_if  in_ch ();
  sgsg_out_if out_ch ();
  sgsg_cfg_if cfg_ch ();

  stratified_grid_sample_generator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the registers and of the sequencing state.
  logic [1:0]                gen_mode;
  logic [1:0]                gen_dims;
  logic [6:0]                gen_cells;
  logic signed [COORD_W-1:0] gen_min;
  logic signed [COORD_W-1:0] gen_max;
  logic [SEED_W-1:0]         lcg_state;
  logic [5:0]                cell_col;    // x
  logic [5:0]                cell_row;    // y
  logic [5:0]                cell_layer;  // z
  logic [15:0]               jit_x, jit_y, jit_z;

  // Points still owed by the block, oldest first.
  point_t pending_points [$];

  // Hand-computed point of the request now on the bus, if any.
  bit     req_known;
  point_t req_want;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          mismatches = 0;

  // ---------------------------------------------------------------------------
  // Point predictor
  // ---------------------------------------------------------------------------

  // Advance the 48-bit generator and take its top 16 bits as a fraction.
  function automatic logic [15:0] lcg_fraction();
    lcg_state = lcg_state * LCG_MULT + LCG_INC;
    return lcg_state[47:32];
  endfunction

  function automatic void clear_cells();
    cell_col   = '0;
    cell_row   = '0;
    cell_layer = '0;
  endfunction

  // min + span*(cell + frac)/cells, quotient truncated toward zero in magnitude.
  // The product stays below 2^55, so plain 64-bit math holds it exactly.
  function automatic logic [31:0] interpolate(logic [5:0] cell_idx, logic [15:0] frac,
                                              int cells);
    longint lo, span, mag, num, den, q, res;
    lo   = longint'(gen_min);
    span = longint'(gen_max) - lo;
    mag  = (span < 0) ? -span : span;
    num  = longint'({cell_idx, 16'h0000}) + longint'(frac);
    den  = longint'(cells) << 16;
    q    = (mag * num) / den;
    res  = (span < 0) ? lo - q : lo + q;
    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    return res[31:0];
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MODE: gen_mode = value[1:0];
      CFG_DIMS: begin
        gen_dims = value[1:0];
        clear_cells();
      end
      CFG_CELLS: begin
        gen_cells = value[6:0];
        clear_cells();
      end
      CFG_RMIN: gen_min = value[31:0];
      CFG_RMAX: gen_max = value[31:0];
      CFG_SEED: lcg_state = value[SEED_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_predictor();
    gen_mode  = MODE_JITTER;
    gen_dims  = 2'd2;
    gen_cells = 7'd8;
    gen_min   = 32'sd0;
    gen_max   = 32'sd65536;
    lcg_state = 48'd20017429951246;
    clear_cells();
    jit_x = '0;
    jit_y = '0;
    jit_z = '0;
  endfunction

  // Work out the point for one request and step the cell counters.
  function automatic point_t next_point(logic restart);
    int          dims, cells, top, a;
    logic [5:0]  grid_pos [3];
    logic [15:0] shift [3];
    logic [31:0] coord [3];
    logic        carry;
    point_t      p;
    dims  = (gen_dims == 2'd0) ? 1 : int'(gen_dims);
    cells = (gen_cells == 7'd0) ? 1 :
            (gen_cells > CELL_LIMIT) ? CELL_LIMIT : int'(gen_cells);
    top   = cells - 1;

    // A restart always draws all three shifts, whatever the mode.
    if (restart) begin
      clear_cells();
      jit_x = lcg_fraction();
      jit_y = lcg_fraction();
      jit_z = lcg_fraction();
    end
    if (cell_col > top)   cell_col   = top[5:0];
    if (cell_row > top)   cell_row   = top[5:0];
    if (cell_layer > top) cell_layer = top[5:0];

    grid_pos = '{cell_col, cell_row, cell_layer};
    shift    = '{jit_x, jit_y, jit_z};

    // Draws happen axis by axis in x, y, z order.
    for (a = 0; a < 3; a++) begin
      coord[a] = '0;
      if (a < dims) begin
        case (gen_mode)
          MODE_RANDOM:  coord[a] = interpolate(6'd0, lcg_fraction(), 1);
          MODE_JITTER:  coord[a] = interpolate(grid_pos[a], lcg_fraction(), cells);
          MODE_UNIFORM: coord[a] = interpolate(grid_pos[a], shift[a], cells);
          default:      coord[a] = interpolate(grid_pos[a], CELL_CENTER, cells);
        endcase
      end
    end
    p.x    = coord[0];
    p.y    = coord[1];
    p.z    = coord[2];
    p.last = (cell_col == top) && (dims < 2 || cell_row == top) &&
             (dims < 3 || cell_layer == top);

    // Step z fastest, then x, then y; wrap to a fresh set after the last cell.
    carry = 1'b1;
    if (dims >= 3) begin
      if (cell_layer < top) begin
        cell_layer++;
        carry = 1'b0;
      end else begin
        cell_layer = '0;
      end
    end
    if (carry) begin
      if (cell_col < top) begin
        cell_col++;
        carry = 1'b0;
      end else begin
        cell_col = '0;
      end
    end
    if (carry && dims >= 2) begin
      if (cell_row < top) cell_row++;
      else cell_row = '0;
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Script rows
  // ---------------------------------------------------------------------------

  function automatic stim_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    stim_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.index  = idx;
    r.data   = value;
    return r;
  endfunction

  function automatic stim_t point_row(logic restart);
    stim_t r;
    r         = '0;
    r.restart = restart;
    return r;
  endfunction

  function automatic stim_t known_row(logic restart, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic last);
    stim_t r;
    r         = '0;
    r.restart = restart;
    r.known   = 1'b1;
    r.want    = '{x, y, z, last};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at a falling edge after the write, with valid
  // dropped at an earlier edge, so valid never sees two assignments in one step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance, with valid
  // dropped at an earlier edge. Drop valid after acceptance so nothing more is taken
  // while the sender drains or writes registers.
  task automatic send_request(input logic restart, input bit known, input point_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    req_known      = known;
    req_want       = want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every owed point has come back.
  task automatic wait_drained();
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'h0001_0000;
      4:       return 32'hFFFF_0000;
      default: return $urandom();
    endcase
  endfunction

  // Rewrite a random subset of the registers. Upper data bits carry noise
  // the block must drop. Cells stay small most of the time so sets close.
  task automatic random_settings();
    logic [CFG_DATA_W-1:0] noise;
    noise = {16'($urandom()), 32'($urandom())};
    if ($urandom_range(1))
      write_register(CFG_MODE, {noise[47:2], 2'($urandom_range(3))});
    if ($urandom_range(1))
      write_register(CFG_DIMS, {noise[47:2], 2'($urandom_range(3))});
    if ($urandom_range(1))
      write_register(CFG_CELLS, {noise[47:7], ($urandom_range(9) == 0) ?
                                 7'($urandom_range(127)) : 7'($urandom_range(4))});
    if ($urandom_range(1))
      write_register(CFG_RMIN, {noise[47:32], pick_bound()});
    if ($urandom_range(1))
      write_register(CFG_RMAX, {noise[47:32], pick_bound()});
    if ($urandom_range(3) == 0)
      write_register(CFG_SEED, {16'($urandom()), 32'($urandom())});
    if ($urandom_range(7) == 0)
      write_register($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, noise);
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict on each accepted request,
  // compare each accepted point with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t want, got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.coord_x, out_ch.coord_y, out_ch.coord_z, out_ch.last_point};
        if (pending_points.size() == 0) begin
          mismatches++;
          $display("%0t: point with none owed, expected nothing, got x=%h y=%h z=%h last=%b",
                   $time, got.x, got.y, got.z, got.last);
        end else begin
          want = pending_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.last !== want.last) begin
            mismatches++;
            $display("%0t: point mismatch, expected x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                     $time, want.x, want.y, want.z, want.last,
                     got.x, got.y, got.z, got.last);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.index, cfg_ch.data);
      // Always run the predictor so its state tracks the block; a
      // hand-computed point, where given, replaces its answer.
      if (in_ch.valid && in_ch.ready) begin
        want = next_point(in_ch.restart);
        if (req_known) want = req_want;
        pending_points = {pending_points, want};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_t script [$];
    int    phase, seg, n;

    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_MODE;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    req_known     = 1'b0;
    req_want      = '0;
    send_idle_pct = 22;
    recv_idle_pct = 81;
    reset_predictor();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Regular-grid and zero-span points are easy to work out
    // by hand; the random-draw rows go through the predictor.
    script = '{
      point_row(1'b0),                        // jittered point straight out of reset
      point_row(1'b1),
      reg_row(CFG_MODE, 48'(MODE_REGULAR)),
      reg_row(CFG_CELLS, 48'd8),
      known_row(1'b0, 32'h0000_1000, 32'h0000_1000, 32'h0, 1'b0),
      known_row(1'b0, 32'h0000_3000, 32'h0000_1000, 32'h0, 1'b0),
      // 2x2 grid: x steps before y, last flag on the fourth point
      reg_row(CFG_CELLS, 48'd2),
      known_row(1'b0, 32'h0000_4000, 32'h0000_4000, 32'h0, 1'b0),
      known_row(1'b0, 32'h0000_C000, 32'h0000_4000, 32'h0, 1'b0),
      known_row(1'b0, 32'h0000_4000, 32'h0000_C000, 32'h0, 1'b0),
      known_row(1'b0, 32'h0000_C000, 32'h0000_C000, 32'h0, 1'b1),
      known_row(1'b1, 32'h0000_4000, 32'h0000_4000, 32'h0, 1'b0),
      // widest positive span, single cell in 3-D
      reg_row(CFG_DIMS, 48'd3),
      reg_row(CFG_CELLS, 48'd1),
      reg_row(CFG_RMIN, 48'h0000_8000_0000),
      reg_row(CFG_RMAX, 48'h0000_7FFF_FFFF),
      known_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
      known_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
      // widest negative span
      reg_row(CFG_RMIN, 48'h0000_7FFF_FFFF),
      reg_row(CFG_RMAX, 48'h0000_8000_0000),
      known_row(1'b0, 32'h0, 32'h0, 32'h0, 1'b1),
      // zero dimensions act as one, zero cells as one
      reg_row(CFG_DIMS, 48'd0),
      reg_row(CFG_RMIN, 48'h0),
      reg_row(CFG_RMAX, 48'h0000_7FFF_FFFF),
      known_row(1'b0, 32'h3FFF_FFFF, 32'h0, 32'h0, 1'b1),
      reg_row(CFG_CELLS, 48'd0),
      known_row(1'b0, 32'h3FFF_FFFF, 32'h0, 32'h0, 1'b1),
      // zero span: every axis lands on the minimum even with random draws
      reg_row(CFG_MODE, 48'(MODE_RANDOM)),
      reg_row(CFG_RMIN, 48'h0000_8000_0000),
      reg_row(CFG_RMAX, 48'h0000_8000_0000),
      reg_row(CFG_DIMS, 48'd3),
      known_row(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1),
      // cells beyond the limit clamp to 64
      reg_row(CFG_RMAX, 48'h0000_7FFF_FFFF),
      reg_row(CFG_CELLS, 48'd127),
      point_row(1'b0),
      point_row(1'b1),
      reg_row(CFG_MODE, 48'(MODE_UNIFORM)),
      point_row(1'b1),
      point_row(1'b0),
      point_row(1'b0),
      // seed extremes and writes to unused indexes
      reg_row(CFG_MODE, 48'(MODE_JITTER)),
      reg_row(CFG_SEED, 48'h0),
      point_row(1'b0),
      point_row(1'b1),
      reg_row(CFG_SEED, 48'hFFFF_FFFF_FFFF),
      reg_row(CFG_SPARE_LO, 48'hFFFF_FFFF_FFFF),
      reg_row(CFG_SPARE_HI, 48'h0),
      point_row(1'b0)
    };

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_drained();
        write_register(script[i].index, script[i].data);
      end else begin
        send_request(script[i].restart, script[i].known, script[i].want);
      end
    end

    // Random part: three idling phases, each a run of settings with a burst
    // of requests. Draining before every settings change doubles as the
    // sender's full pause.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 8; seg++) begin
        wait_drained();
        random_settings();
        for (n = 0; n < 17; n++) send_request($urandom_range(7) == 0, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    // Let the tail drain, then watch for stray points.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
